>>> rtl/cmac_pkg.sv
// shared types, constants and functions for the aes cmac tag engine
// aes round, s-box table and cmac subkey doubling; no dependencies
package cmac_pkg;

   localparam int unsigned BLOCK_BYTES = 16;
   localparam logic [7:0]  CMAC_RB     = 8'h87;
   localparam logic [7:0]  CMAC_PAD    = 8'h80;

   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] MODE_128 = 2'd0;
   localparam logic [1:0] MODE_192 = 2'd1;
   localparam logic [1:0] MODE_256 = 2'd2;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_MODE = 3'd4;

   localparam logic [4:0] FULL_COUNT = 5'd16;

   typedef struct packed {
      logic       start_load;
      logic       upd_load;
      logic       fin_load;
      logic       kexp_step;
      logic       kexp_first;
      logic       kexp_rot;
      logic       kexp_sub;
      logic [5:0] kexp_idx;
      logic       rnd_step;
      logic [3:0] rnd_idx;
      logic       rnd_last;
      logic       subkey_load;
      logic       tag_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       out_busy;
   } status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // one cipher round: sub bytes, shift rows, mix columns unless last, add round key
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, all;
      logic [127:0] r;
      int           src;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            src = w + 4 * ((c + w) & 3);
            t[w + 4 * c] = SBOX[s[127 - 8 * src -: 8]];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
            t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int b = 0; b < 16; b++) begin
         r[127 - 8 * b -: 8] = t[b];
      end
      aes_round = r ^ rk;
   endfunction

   function automatic logic [127:0] dbl_block(input logic [127:0] v);
      dbl_block = {v[126:0], 1'b0} ^ {120'd0, (v[127] ? CMAC_RB : 8'h00)};
   endfunction

endpackage

>>> rtl/cmac_ctrl.sv
// controller for the aes cmac tag engine: sequences key expansion and rounds
// depends on cmac_pkg; drives cmac_dp through cmd_type, reads status_type
module cmac_ctrl
   import cmac_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [4:0] req_byte_count,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_KEXP = 2'd1;
   localparam logic [1:0] S_ENC  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [5:0] widx_ff, widx_in;
   logic [2:0] kmod_ff, kmod_in;
   logic [3:0] rnd_ff, rnd_in;
   logic [1:0] op_ff, op_in;

   logic [3:0] nk;
   logic [3:0] nr;
   logic [5:0] total;
   logic       accept;
   logic       first;

   always_comb begin
      case (status.mode)
         MODE_192: nk = 4'd6;
         MODE_256: nk = 4'd8;
         default:  nk = 4'd4;
      endcase
   end

   assign nr        = nk + 4'd6;
   assign total     = {nr + 4'd1, 2'b00};
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign first     = (widx_ff < {2'b00, nk});

   always_comb begin
      state_in = state_ff;
      widx_in  = widx_ff;
      kmod_in  = kmod_ff;
      rnd_in   = rnd_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.kexp_idx   = widx_ff;
      cmd.kexp_first = first;
      cmd.kexp_rot   = !first && (kmod_ff == 3'd0);
      cmd.kexp_sub   = !first && (nk == 4'd8) && (kmod_ff == 3'd4);
      cmd.rnd_idx    = rnd_ff;
      cmd.rnd_last   = (rnd_ff == nr);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rnd_in = 4'd0;
               op_in  = req_op;
               case (req_op)
                  OP_START: begin
                     cmd.start_load = 1'b1;
                     widx_in  = 6'd0;
                     kmod_in  = 3'd0;
                     state_in = S_KEXP;
                  end
                  OP_UPDATE: begin
                     cmd.upd_load = 1'b1;
                     state_in = S_ENC;
                  end
                  OP_FINISH: begin
                     if (req_byte_count <= FULL_COUNT) begin
                        cmd.fin_load = 1'b1;
                        state_in = S_ENC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_KEXP: begin
            cmd.kexp_step = 1'b1;
            widx_in = widx_ff + 6'd1;
            kmod_in = (kmod_ff == nk[2:0] - 3'd1) ? 3'd0 : kmod_ff + 3'd1;
            if (widx_ff == total - 6'd1) begin
               state_in = (op_ff == OP_START) ? S_ENC : S_IDLE;
            end
         end
         S_ENC: begin
            cmd.rnd_step = 1'b1;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == nr) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            case (op_ff)
               OP_START: begin
                  cmd.subkey_load = 1'b1;
                  state_in = S_IDLE;
               end
               OP_FINISH: begin
                  if (!status.out_busy) begin
                     cmd.tag_load = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // reset runs one expansion of the all-zero key
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_KEXP;
         widx_ff  <= 6'd0;
         kmod_ff  <= 3'd0;
         rnd_ff   <= 4'd0;
         op_ff    <= OP_NONE;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         kmod_ff  <= kmod_in;
         rnd_ff   <= rnd_in;
         op_ff    <= op_in;
      end
   end

`ifndef SYNTH
   a_tag_free: assert property (@(posedge clock) disable iff (reset)
      cmd.tag_load |-> !status.out_busy) else $error("tag loaded over pending word");
   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ENC && cmd.rnd_last) |=> state_ff == S_FIN)
      else $error("last round not followed by finish state");
   a_widx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEXP) |-> (widx_ff < total)) else $error("key word index overrun");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start_load, cmd.upd_load, cmd.fin_load, cmd.rnd_step,
                cmd.subkey_load, cmd.kexp_step})) else $error("conflicting datapath commands");
`endif

endmodule

>>> rtl/cmac_dp.sv
// datapath for the aes cmac tag engine: key registers, round keys, chain, subkeys, tag
// depends on cmac_pkg; commanded by cmac_ctrl
module cmac_dp
   import cmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic [4:0]  req_byte_count,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag_high,
   output logic [63:0] rsp_tag_low
);

   logic [63:0]  key_ff [4];
   logic [1:0]   mode_ff;
   logic [255:0] key_lat_ff;
   logic [1:0]   mode_lat_ff;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] k1_ff, k2_ff;
   logic [127:0] k1_in;
   logic [127:0] rk_ff [15];
   logic [31:0]  win_ff [8];
   logic [7:0]   rcon_ff;
   logic [127:0] tag_ff;
   logic         rsp_valid_ff;

   logic [31:0]  kw [8];
   logic [31:0]  tmp;
   logic [31:0]  far;
   logic [31:0]  word_in;
   logic [127:0] msg;
   logic [127:0] pad;
   logic [127:0] rk_rd;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         kw[j] = key_lat_ff[255 - 32 * j -: 32];
      end
   end

   always_comb begin
      case (mode_lat_ff)
         MODE_192: far = win_ff[5];
         MODE_256: far = win_ff[7];
         default:  far = win_ff[3];
      endcase
   end

   always_comb begin
      tmp = win_ff[0];
      if (cmd.kexp_rot) begin
         tmp = {SBOX[win_ff[0][23:16]] ^ rcon_ff, SBOX[win_ff[0][15:8]],
                SBOX[win_ff[0][7:0]], SBOX[win_ff[0][31:24]]};
      end else if (cmd.kexp_sub) begin
         tmp = {SBOX[win_ff[0][31:24]], SBOX[win_ff[0][23:16]],
                SBOX[win_ff[0][15:8]], SBOX[win_ff[0][7:0]]};
      end
      word_in = cmd.kexp_first ? kw[cmd.kexp_idx[2:0]] : (far ^ tmp);
   end

   // pad the last block: keep bytes below count, then the pad marker
   always_comb begin
      msg = {req_block_high, req_block_low};
      for (int b = 0; b < 16; b++) begin
         if (5'(b) < req_byte_count) begin
            pad[127 - 8 * b -: 8] = msg[127 - 8 * b -: 8];
         end else if (5'(b) == req_byte_count) begin
            pad[127 - 8 * b -: 8] = CMAC_PAD;
         end else begin
            pad[127 - 8 * b -: 8] = 8'h00;
         end
      end
   end

   assign rk_rd = rk_ff[cmd.rnd_idx];
   assign k1_in = dbl_block(chain_ff);

   always_comb begin
      chain_in = chain_ff;
      if (cmd.start_load || cmd.subkey_load) begin
         chain_in = '0;
      end else if (cmd.upd_load) begin
         chain_in = chain_ff ^ msg;
      end else if (cmd.fin_load) begin
         chain_in = chain_ff ^ pad ^ ((req_byte_count == FULL_COUNT) ? k1_ff : k2_ff);
      end else if (cmd.rnd_step) begin
         chain_in = (cmd.rnd_idx == 4'd0) ? (chain_ff ^ rk_rd)
                                          : aes_round(chain_ff, rk_rd, cmd.rnd_last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 4; j++) begin
            key_ff[j] <= '0;
         end
         mode_ff      <= MODE_128;
         key_lat_ff   <= '0;
         mode_lat_ff  <= MODE_128;
         chain_ff     <= '0;
         k1_ff        <= '0;
         k2_ff        <= '0;
         rcon_ff      <= 8'h01;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_KEY0: key_ff[0] <= csr_wdata;
               CSR_KEY1: key_ff[1] <= csr_wdata;
               CSR_KEY2: key_ff[2] <= csr_wdata;
               CSR_KEY3: key_ff[3] <= csr_wdata;
               CSR_MODE: mode_ff   <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
         if (cmd.start_load) begin
            key_lat_ff  <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
            mode_lat_ff <= mode_ff;
            rcon_ff     <= 8'h01;
         end else if (cmd.kexp_step && cmd.kexp_rot) begin
            rcon_ff <= xtime(rcon_ff);
         end
         chain_ff <= chain_in;
         if (cmd.subkey_load) begin
            k1_ff <= k1_in;
            k2_ff <= dbl_block(k1_in);
         end
         if (cmd.tag_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kexp_step) begin
         rk_ff[cmd.kexp_idx[5:2]][{~cmd.kexp_idx[1:0], 5'b00000} +: 32] <= word_in;
         win_ff[0] <= word_in;
         for (int j = 1; j < 8; j++) begin
            win_ff[j] <= win_ff[j - 1];
         end
      end
      if (cmd.tag_load) begin
         tag_ff <= chain_ff;
      end
   end

   assign status.mode     = mode_lat_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tag_high    = tag_ff[127:64];
   assign rsp_tag_low     = tag_ff[63:0];

endmodule

>>> rtl/aes_cmac_tag_engine_core.sv
// aes cmac tag engine top level: start expands 44/52/60 round key words, then
// runs the cipher (nr 10/12/14) to make the subkeys; update and finish each run
// the cipher, one aes round per cycle in a single shared round unit; finish then
// registers the tag. one word in flight at a time; req_stall is high while a
// word is processed. synchronous active-high reset clears key, chain and subkeys,
// then expands the all-zero aes-128 key before the first word is taken.
module aes_cmac_tag_engine_core
   import cmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag_high,
   output logic [63:0] rsp_tag_low
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cmac_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_byte_count (req_byte_count),
      .status         (status),
      .cmd            (cmd)
   );

   cmac_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_block_high (req_block_high),
      .req_block_low  (req_block_low),
      .req_byte_count (req_byte_count),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tag_high   (rsp_tag_high),
      .rsp_tag_low    (rsp_tag_low)
   );

endmodule
